>>> sv/u8tok_pkg.sv
package u8tok_pkg;

  localparam int TableEntriesDef = 64;
  localparam int IdxW            = 6;
  localparam int KeyBytes        = 8;
  localparam int KeyW            = 64;
  localparam int LenW            = 4;
  localparam int IdW             = 16;
  localparam int ByteW           = 8;
  localparam int InDataW         = 104;
  localparam int OutDataW        = 16;

  localparam logic [7:0] MASK_80 = 8'h80;
  localparam logic [7:0] MASK_E0 = 8'hE0;
  localparam logic [7:0] MASK_C0 = 8'hC0;
  localparam logic [7:0] MASK_F0 = 8'hF0;
  localparam logic [7:0] MASK_F8 = 8'hF8;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_TEXT = 1'b1
  } op_e;

  typedef struct packed {
    op_e              op;
    logic [IdxW-1:0]  idx;
    logic             ent_valid;
    logic [KeyW-1:0]  key;
    logic [LenW-1:0]  klen;
    logic [IdW-1:0]   id;
    logic [ByteW-1:0] text_byte;
    logic             last;
  } cmd_t;

  typedef struct packed {
    logic            valid;
    logic [KeyW-1:0] key;
    logic [LenW-1:0] klen;
    logic [IdW-1:0]  id;
  } entry_t;

  typedef enum logic [1:0] {
    CP_BAD,
    CP_OK,
    CP_WAIT
  } cp_stat_e;

  typedef struct packed {
    cp_stat_e   stat;
    logic [2:0] len;
  } cp_res_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EVAL,
    ST_SCAN,
    ST_EMIT,
    ST_DONE
  } tok_state_e;

  function automatic logic [2:0] lead_len(input logic [7:0] b);
    logic [2:0] n;
    if ((b & MASK_80) == 8'h00) n = 3'd1;
    else if ((b & MASK_E0) == MASK_C0) n = 3'd2;
    else if ((b & MASK_F0) == MASK_E0) n = 3'd3;
    else if ((b & MASK_F8) == MASK_F0) n = 3'd4;
    else n = 3'd0;
    return n;
  endfunction

endpackage

>>> sv/u8tok_ram.sv
module u8tok_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> sv/u8tok_front.sv
module u8tok_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // idx[5:0], entry_valid[6], key[70:7], key_len[74:71], id[90:75], byte[98:91]
  input  logic [u8tok_pkg::InDataW-1:0] s_tdata,
  input  logic                          s_tuser,  // op
  input  logic                          s_tlast,  // text_last
  input  logic                          busy,
  output logic                          cmd_valid,
  input  logic                          cmd_ready,
  output u8tok_pkg::cmd_t               cmd
);
  import u8tok_pkg::*;

  cmd_t       q [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  cmd_t       in_cmd;
  logic       push;
  logic       pop;

  always_comb begin
    in_cmd.op        = op_e'(s_tuser);
    in_cmd.idx       = s_tdata[5:0];
    in_cmd.ent_valid = s_tdata[6];
    in_cmd.key       = s_tdata[70:7];
    in_cmd.klen      = s_tdata[74:71];
    in_cmd.id        = s_tdata[90:75];
    in_cmd.text_byte = s_tdata[98:91];
    in_cmd.last      = s_tlast;
  end

  assign s_tready  = (count != 2'd2) && !busy;
  assign cmd_valid = (count != 2'd0);
  assign cmd       = q[rd_ptr];
  assign push      = s_tvalid && s_tready;
  assign pop       = cmd_valid && cmd_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= in_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

`ifndef SYNTHESIS
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    count == 2'd2 |-> !push) else $error("queue overrun");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    count == 2'd0 |=> count != 2'd3) else $error("queue count corrupt");
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> count == $past(count) + 2'd1) else $error("queue count slip");
`endif

endmodule

>>> sv/u8tok_back.sv
module u8tok_back #(
  parameter int TABLE_ENTRIES = u8tok_pkg::TableEntriesDef
) (
  input  logic                           clk,
  input  logic                           rst,
  output logic                           busy,
  input  logic                           cmd_valid,
  output logic                           cmd_ready,
  input  u8tok_pkg::cmd_t                cmd,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [u8tok_pkg::OutDataW-1:0] m_tdata,
  output logic                           m_tuser,
  output logic                           m_tlast
);
  import u8tok_pkg::*;

  localparam int AW = $clog2(TABLE_ENTRIES);
  localparam logic [AW:0]   NUM  = (AW+1)'(TABLE_ENTRIES);
  localparam logic [AW-1:0] LAST = AW'(TABLE_ENTRIES - 1);
  localparam int EW = $bits(entry_t);

  tok_state_e            state, state_next;
  logic [7:0][7:0]       pend, pend_next;
  logic [3:0]            cnt, cnt_next;
  logic                  fin, fin_next;
  logic                  hold_v, hold_v_next;
  logic [IdW-1:0]        hold_id, hold_id_next;
  logic [AW:0]           scan_idx, scan_idx_next;
  logic                  cmp_v, cmp_v_next;
  logic [3:0]            scan_len, scan_len_next;
  logic                  scan_pair, scan_pair_next;
  logic [2:0]            cur_n, cur_n_next;
  logic [3:0]            drop_n, drop_n_next;
  logic [IdW-1:0]        hit_id, hit_id_next;
  logic [AW-1:0]         clr_idx, clr_idx_next;
  logic                  out_v, out_v_next;
  logic                  out_tv, out_tv_next;
  logic [IdW-1:0]        out_id, out_id_next;
  logic                  out_end, out_end_next;

  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  entry_t                ram_wdata;
  logic [EW-1:0]         ram_rdata;
  entry_t                ent;
  cp_res_t               cp0, cp1;
  logic                  match;
  logic                  out_free;
  logic                  issue;

  u8tok_ram #(.WIDTH(EW), .DEPTH(TABLE_ENTRIES)) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (scan_idx[AW-1:0]),
    .rdata (ram_rdata)
  );

  function automatic cp_res_t cp_at(input logic [7:0][7:0] pb, input logic [3:0] c,
                                    input logic [3:0] pos, input logic f);
    cp_res_t    r;
    logic [2:0] n;
    logic [3:0] p;
    r.stat = CP_OK;
    r.len  = 3'd0;
    n      = 3'd0;
    if (pos >= c) begin
      r.stat = f ? CP_BAD : CP_WAIT;
    end else begin
      n = lead_len(pb[pos[2:0]]);
      if (n == 3'd0) begin
        r.stat = CP_BAD;
      end else if (pos + {1'b0, n} > c) begin
        r.stat = f ? CP_BAD : CP_WAIT;
      end else begin
        r.len = n;
        for (int k = 1; k < 4; k++) begin
          p = pos + 4'(k);
          if (3'(k) < n && (pb[p[2:0]] & MASK_C0) != MASK_80) r.stat = CP_BAD;
        end
      end
    end
    return r;
  endfunction

  assign ent       = entry_t'(ram_rdata);
  assign busy      = (state == ST_CLEAR);
  assign m_tvalid  = out_v;
  assign m_tdata   = out_id;
  assign m_tuser   = out_tv;
  assign m_tlast   = out_end;
  assign out_free  = !out_v || m_tready;
  assign issue     = scan_idx < NUM;
  assign cp0       = cp_at(pend, cnt, 4'd0, fin);
  assign cp1       = cp_at(pend, cnt, {1'b0, cp0.len}, fin);

  always_comb begin
    match = ent.valid && (ent.klen == scan_len);
    for (int k = 0; k < KeyBytes; k++) begin
      if (4'(k) < scan_len && ent.key[8*k +: 8] != pend[k]) match = 1'b0;
    end
  end

  always_comb begin
    state_next     = state;
    pend_next      = pend;
    cnt_next       = cnt;
    fin_next       = fin;
    hold_v_next    = hold_v;
    hold_id_next   = hold_id;
    scan_idx_next  = scan_idx;
    cmp_v_next     = cmp_v;
    scan_len_next  = scan_len;
    scan_pair_next = scan_pair;
    cur_n_next     = cur_n;
    drop_n_next    = drop_n;
    hit_id_next    = hit_id;
    clr_idx_next   = clr_idx;
    out_v_next     = out_v && !m_tready;
    out_tv_next    = out_tv;
    out_id_next    = out_id;
    out_end_next   = out_end;
    ram_we         = 1'b0;
    ram_waddr      = clr_idx;
    ram_wdata      = '0;
    cmd_ready      = 1'b0;

    case (state)
      ST_CLEAR: begin
        ram_we       = 1'b1;
        clr_idx_next = clr_idx + 1'b1;
        if (clr_idx == LAST) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        cmd_ready = 1'b1;
        if (cmd_valid) begin
          if (cmd.op == OP_LOAD) begin
            if (int'(cmd.idx) < TABLE_ENTRIES) begin
              ram_we          = 1'b1;
              ram_waddr       = AW'(cmd.idx);
              ram_wdata.valid = cmd.ent_valid;
              ram_wdata.key   = cmd.key;
              ram_wdata.klen  = cmd.klen;
              ram_wdata.id    = cmd.id;
            end
          end else begin
            if (cnt < 4'd8) begin
              pend_next[cnt[2:0]] = cmd.text_byte;
              cnt_next            = cnt + 4'd1;
            end
            fin_next   = cmd.last;
            state_next = ST_EVAL;
          end
        end
      end
      ST_EVAL: begin
        if (cnt == 4'd0) begin
          state_next = ST_DONE;
        end else begin
          case (cp0.stat)
            CP_WAIT: state_next = ST_DONE;
            CP_BAD: begin
              pend_next = pend >> 8;
              cnt_next  = cnt - 4'd1;
            end
            CP_OK: begin
              cur_n_next = cp0.len;
              if (cp1.stat == CP_WAIT) begin
                state_next = ST_DONE;
              end else begin
                scan_idx_next  = '0;
                cmp_v_next     = 1'b0;
                scan_pair_next = (cp1.stat == CP_OK);
                scan_len_next  = (cp1.stat == CP_OK) ?
                                 {1'b0, cp0.len} + {1'b0, cp1.len} : {1'b0, cp0.len};
                state_next     = ST_SCAN;
              end
            end
            default: state_next = ST_DONE;
          endcase
        end
      end
      ST_SCAN: begin
        cmp_v_next = issue;
        if (issue) scan_idx_next = scan_idx + 1'b1;
        if (cmp_v && match) begin
          hit_id_next = ent.id;
          drop_n_next = scan_len;
          state_next  = ST_EMIT;
        end else if (!issue && !cmp_v) begin
          if (scan_pair) begin
            scan_pair_next = 1'b0;
            scan_len_next  = {1'b0, cur_n};
            scan_idx_next  = '0;
            cmp_v_next     = 1'b0;
          end else begin
            pend_next  = pend >> {cur_n, 3'b000};
            cnt_next   = ({1'b0, cur_n} >= cnt) ? 4'd0 : cnt - {1'b0, cur_n};
            state_next = ST_EVAL;
          end
        end
      end
      ST_EMIT: begin
        if (!hold_v || out_free) begin
          if (hold_v) begin
            out_v_next   = 1'b1;
            out_tv_next  = 1'b1;
            out_id_next  = hold_id;
            out_end_next = 1'b0;
          end
          hold_v_next  = 1'b1;
          hold_id_next = hit_id;
          pend_next    = pend >> {drop_n, 3'b000};
          cnt_next     = (drop_n >= cnt) ? 4'd0 : cnt - drop_n;
          state_next   = ST_EVAL;
        end
      end
      ST_DONE: begin
        if (!(fin || hold_v) || out_free) begin
          if (fin) begin
            cnt_next     = 4'd0;
            out_v_next   = 1'b1;
            out_tv_next  = hold_v;
            out_id_next  = hold_v ? hold_id : '0;
            out_end_next = 1'b1;
          end else if (hold_v) begin
            out_v_next   = 1'b1;
            out_tv_next  = 1'b1;
            out_id_next  = hold_id;
            out_end_next = 1'b0;
          end
          hold_v_next = 1'b0;
          state_next  = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      cnt     <= 4'd0;
      hold_v  <= 1'b0;
      out_v   <= 1'b0;
      clr_idx <= '0;
      cmp_v   <= 1'b0;
    end else begin
      state   <= state_next;
      cnt     <= cnt_next;
      hold_v  <= hold_v_next;
      out_v   <= out_v_next;
      clr_idx <= clr_idx_next;
      cmp_v   <= cmp_v_next;
    end
  end

  always_ff @(posedge clk) begin
    pend      <= pend_next;
    fin       <= fin_next;
    hold_id   <= hold_id_next;
    scan_idx  <= scan_idx_next;
    scan_len  <= scan_len_next;
    scan_pair <= scan_pair_next;
    cur_n     <= cur_n_next;
    drop_n    <= drop_n_next;
    hit_id    <= hit_id_next;
    out_tv    <= out_tv_next;
    out_id    <= out_id_next;
    out_end   <= out_end_next;
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= 4'd8) else $error("pending count overflow");
  a_idle_no_hold: assert property (@(posedge clk) disable iff (rst)
    state == ST_IDLE |-> !hold_v) else $error("token held across items");
  a_fin_flush: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && fin && out_free) |=> cnt == 4'd0)
    else $error("pending bytes survive end of string");
  a_scan_len: assert property (@(posedge clk) disable iff (rst)
    state == ST_SCAN |-> (scan_len != 4'd0 && scan_len <= 4'd8))
    else $error("bad key length in search");
`endif

endmodule

>>> sv/utf8_greedy_vocab_tokenizer_top.sv
// Greedy longest-match UTF-8 tokenizer.
// Slave stream: tuser selects the beat kind (0 loads a vocabulary slot, 1 carries
// one text byte); tlast marks the final byte of a string. Master stream: tdata is
// the token id, tuser says the id is a real token, tlast closes the string.
// Beats enter a two-deep queue; the tokenizer engine drains it one item at a time.
// A load goes into the table as the engine takes it. A text byte enters the engine,
// bytes found malformed are dropped one by one, and the engine finishes the item. Each
// codepoint resolved is decoded, then looked up by one or two table searches, walking
// the single table memory port one slot a cycle, lowest slot first, and stopping on a
// hit. A hit is then emitted. Up to four results come out of one byte.
// After reset a pass over every slot clears the table valid bits;
// s_tready stays low until it completes. Pending text bytes are discarded.
// When the receiver stalls, the output register holds its beat and the engine waits once
// it has another beat to send; the input queue keeps taking beats until it is full.
module utf8_greedy_vocab_tokenizer_top #(
  parameter int TABLE_ENTRIES = u8tok_pkg::TableEntriesDef
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // entry_index[5:0], entry_valid[6], entry_key[70:7], entry_key_len[74:71],
  // entry_id[90:75], text_byte[98:91], zero fill[103:99]
  input  logic [u8tok_pkg::InDataW-1:0]  s_tdata,
  input  logic                           s_tuser,  // op
  input  logic                           s_tlast,  // text_last
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [u8tok_pkg::OutDataW-1:0] m_tdata,  // token_id[15:0]
  output logic                           m_tuser,  // token_valid
  output logic                           m_tlast   // text_end
);
  import u8tok_pkg::*;

  logic busy;
  logic cmd_valid;
  logic cmd_ready;
  cmd_t cmd;

  u8tok_front u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .s_tlast   (s_tlast),
    .busy      (busy),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd)
  );

  u8tok_back #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_back (
    .clk       (clk),
    .rst       (rst),
    .busy      (busy),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

endmodule
